[hw/rtl/long_press_touch_detector_assert.svh]
// ----------------------------------------------------------------------------
// long press touch detector assertion macros
// concurrent checks clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef LONG_PRESS_TOUCH_DETECTOR_ASSERT_SVH
`define LONG_PRESS_TOUCH_DETECTOR_ASSERT_SVH

// property must hold at every edge out of reset
`define LPTD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the same edge
`define LPTD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[hw/rtl/lptd_pkg.sv]
// ----------------------------------------------------------------------------
// lptd_pkg
// types and constants shared by the long press touch detector files
// ----------------------------------------------------------------------------
package lptd_pkg;

	localparam int COORD_BITS_DEF = 13;
	localparam int TIME_BITS_DEF  = 32;

	localparam int HOLD_BITS = 16;
	localparam int MOVE_BITS = 12;
	localparam int DIM_BITS  = 13;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_ENABLE       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_MS      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_MOVEMENT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_VIEW_LEFT    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_VIEW_TOP     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_VIEW_WIDTH   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_VIEW_HEIGHT  = 3'd6;

	localparam logic [HOLD_BITS-1:0]   HOLD_RST   = 16'd500;
	localparam logic [MOVE_BITS-1:0]   MOVE_RST   = 12'd10;
	localparam logic [DIM_BITS-1:0]    WIDTH_RST  = 13'd960;
	localparam logic [DIM_BITS-1:0]    HEIGHT_RST = 13'd544;
	localparam logic [2*MOVE_BITS-1:0] MOVE_SQ_RST = 24'd100;

	typedef enum logic [1:0] {
		PH_NONE  = 2'd0,
		PH_START = 2'd1,
		PH_STAY  = 2'd2,
		PH_END   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		GS_FAILED  = 2'd0,
		GS_UNSURE  = 2'd1,
		GS_STARTED = 2'd2,
		GS_ENDED   = 2'd3
	} gesture_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_STARTED = 2'd1,
		EV_ENDED   = 2'd2
	} event_t;

endpackage

[hw/rtl/lptd_if.sv]
// ----------------------------------------------------------------------------
// lptd channel interfaces
// valid/ready channels for touch samples and gesture results
// ----------------------------------------------------------------------------
interface lptd_sample_if
	import lptd_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	phase_t                       touch_phase;
	logic signed [COORD_BITS-1:0] touch_x;
	logic signed [COORD_BITS-1:0] touch_y;
	phase_t                       mouse_phase;
	logic signed [COORD_BITS-1:0] mouse_x;
	logic signed [COORD_BITS-1:0] mouse_y;
	logic        [TIME_BITS-1:0]  now_ms;

	modport source (
		output valid, touch_phase, touch_x, touch_y, mouse_phase, mouse_x, mouse_y, now_ms,
		input  ready
	);
	modport sink (
		input  valid, touch_phase, touch_x, touch_y, mouse_phase, mouse_x, mouse_y, now_ms,
		output ready
	);
endinterface

interface lptd_result_if
	import lptd_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	gesture_t                     gesture_state;
	event_t                       event_kind;
	logic signed [COORD_BITS-1:0] event_x;
	logic signed [COORD_BITS-1:0] event_y;
	logic                         play_click;

	modport source (
		output valid, gesture_state, event_kind, event_x, event_y, play_click,
		input  ready
	);
	modport sink (
		input  valid, gesture_state, event_kind, event_x, event_y, play_click,
		output ready
	);
endinterface

[hw/rtl/long_press_touch_detector.sv]
// a sample is held in the input register, then in the result register
// one sample per cycle without result stalls; gesture flags update with the result
// result stalls hold the input register, which takes one more sample only while empty
// reset: arst_n asynchronous active low, clears pipeline valids and gesture state,
// loads the configuration registers with their defaults
// ----------------------------------------------------------------------------
// long_press_touch_detector
// long press recognizer over touch or mouse samples with apb configuration
// ----------------------------------------------------------------------------
module long_press_touch_detector
	import lptd_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	lptd_sample_if.sink       sample,
	lptd_result_if.source     result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int BND_W = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;
	localparam int SQ_W  = 2 * (COORD_BITS + 1);
	localparam int D_W   = SQ_W + 1;
	localparam int CMP_W = (D_W > 2 * MOVE_BITS) ? D_W : 2 * MOVE_BITS;

	// configuration
	logic                         enable_q;
	logic [HOLD_BITS-1:0]         hold_ms_q;
	logic [MOVE_BITS-1:0]         max_movement_q;
	logic [2*MOVE_BITS-1:0]       move_sq_q;
	logic signed [COORD_BITS-1:0] view_left_q;
	logic signed [COORD_BITS-1:0] view_top_q;
	logic [DIM_BITS-1:0]          view_width_q;
	logic [DIM_BITS-1:0]          view_height_q;
	logic                         cfg_wr;
	logic [REG_IDX_W-1:0]         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b1;
			hold_ms_q      <= HOLD_RST;
			max_movement_q <= MOVE_RST;
			move_sq_q      <= MOVE_SQ_RST;
			view_left_q    <= '0;
			view_top_q     <= '0;
			view_width_q   <= WIDTH_RST;
			view_height_q  <= HEIGHT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ENABLE:       enable_q <= pwdata[0];
				REG_HOLD_MS:      hold_ms_q <= pwdata[HOLD_BITS-1:0];
				REG_MAX_MOVEMENT: begin
					max_movement_q <= pwdata[MOVE_BITS-1:0];
					move_sq_q      <= pwdata[MOVE_BITS-1:0] * pwdata[MOVE_BITS-1:0];
				end
				REG_VIEW_LEFT:    view_left_q <= $signed(pwdata[COORD_BITS-1:0]);
				REG_VIEW_TOP:     view_top_q <= $signed(pwdata[COORD_BITS-1:0]);
				REG_VIEW_WIDTH:   view_width_q <= pwdata[DIM_BITS-1:0];
				REG_VIEW_HEIGHT:  view_height_q <= pwdata[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ENABLE:       prdata = DATA_W'(enable_q);
			REG_HOLD_MS:      prdata = DATA_W'(hold_ms_q);
			REG_MAX_MOVEMENT: prdata = DATA_W'(max_movement_q);
			REG_VIEW_LEFT:    prdata = DATA_W'($unsigned(view_left_q));
			REG_VIEW_TOP:     prdata = DATA_W'($unsigned(view_top_q));
			REG_VIEW_WIDTH:   prdata = DATA_W'(view_width_q);
			REG_VIEW_HEIGHT:  prdata = DATA_W'(view_height_q);
			default:          prdata = '0;
		endcase
	end

	// input register
	logic                         v_s1;
	logic                         adv;
	phase_t                       tph_s1;
	phase_t                       mph_s1;
	logic signed [COORD_BITS-1:0] tx_s1;
	logic signed [COORD_BITS-1:0] ty_s1;
	logic signed [COORD_BITS-1:0] mx_s1;
	logic signed [COORD_BITS-1:0] my_s1;
	logic [TIME_BITS-1:0]         now_s1;

	assign adv          = !result.valid || result.ready;
	assign sample.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample.ready) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			tph_s1 <= sample.touch_phase;
			mph_s1 <= sample.mouse_phase;
			tx_s1  <= sample.touch_x;
			ty_s1  <= sample.touch_y;
			mx_s1  <= sample.mouse_x;
			my_s1  <= sample.mouse_y;
			now_s1 <= sample.now_ms;
		end
	end

	// gesture state
	logic                         tracking_q;
	logic                         triggered_q;
	gesture_t                     gesture_q;
	logic signed [COORD_BITS-1:0] start_x_q;
	logic signed [COORD_BITS-1:0] start_y_q;
	logic [TIME_BITS-1:0]         start_time_q;

	// single pass evaluation
	phase_t                       ph;
	logic signed [COORD_BITS-1:0] px;
	logic signed [COORD_BITS-1:0] py;
	logic signed [BND_W-1:0]      x_w;
	logic signed [BND_W-1:0]      y_w;
	logic signed [BND_W-1:0]      l_w;
	logic signed [BND_W-1:0]      t_w;
	logic signed [BND_W-1:0]      r_w;
	logic signed [BND_W-1:0]      b_w;
	logic                         out_of_view;
	logic signed [COORD_BITS:0]   dx;
	logic signed [COORD_BITS:0]   dy;
	logic signed [SQ_W-1:0]       dx2;
	logic signed [SQ_W-1:0]       dy2;
	logic [D_W-1:0]               d2;
	logic                         too_far;
	logic [TIME_BITS-1:0]         elapsed;
	logic                         held;

	assign ph = (tph_s1 == PH_NONE) ? mph_s1 : tph_s1;
	assign px = (tph_s1 == PH_NONE) ? mx_s1 : tx_s1;
	assign py = (tph_s1 == PH_NONE) ? my_s1 : ty_s1;

	assign x_w = BND_W'(px);
	assign y_w = BND_W'(py);
	assign l_w = BND_W'(view_left_q);
	assign t_w = BND_W'(view_top_q);
	assign r_w = l_w + BND_W'($signed({1'b0, view_width_q}));
	assign b_w = t_w + BND_W'($signed({1'b0, view_height_q}));
	assign out_of_view = (x_w < l_w) || (x_w > r_w) || (y_w < t_w) || (y_w > b_w);

	assign dx      = (COORD_BITS + 1)'(px) - (COORD_BITS + 1)'(start_x_q);
	assign dy      = (COORD_BITS + 1)'(py) - (COORD_BITS + 1)'(start_y_q);
	assign dx2     = dx * dx;
	assign dy2     = dy * dy;
	assign d2      = D_W'($unsigned(dx2)) + D_W'($unsigned(dy2));
	assign too_far = CMP_W'(d2) > CMP_W'(move_sq_q);

	assign elapsed = now_s1 - start_time_q;
	assign held    = elapsed >= TIME_BITS'(hold_ms_q);

	logic     tracking_d;
	logic     triggered_d;
	gesture_t gesture_d;
	event_t   ev_d;
	logic     click_d;
	logic     latch_start;

	always_comb begin
		tracking_d  = tracking_q;
		triggered_d = triggered_q;
		gesture_d   = gesture_q;
		ev_d        = EV_NONE;
		click_d     = 1'b0;
		latch_start = 1'b0;
		if (!enable_q || ph == PH_NONE) begin
			tracking_d = 1'b0;
			gesture_d  = GS_FAILED;
		end else begin
			case (ph)
				PH_START: begin
					tracking_d  = 1'b1;
					triggered_d = 1'b0;
					latch_start = 1'b1;
					gesture_d   = GS_UNSURE;
				end
				PH_STAY: begin
					if (tracking_q && !triggered_q) begin
						if (out_of_view || too_far) begin
							tracking_d = 1'b0;
							gesture_d  = GS_FAILED;
						end else if (held) begin
							triggered_d = 1'b1;
							gesture_d   = GS_STARTED;
							ev_d        = EV_STARTED;
							click_d     = 1'b1;
						end
					end
				end
				default: begin
					if (triggered_q) begin
						gesture_d = GS_ENDED;
						ev_d      = EV_ENDED;
					end else begin
						gesture_d = GS_FAILED;
					end
					tracking_d = 1'b0;
				end
			endcase
		end
	end

	logic fire;
	assign fire = v_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q   <= 1'b0;
			triggered_q  <= 1'b0;
			gesture_q    <= GS_FAILED;
			result.valid <= 1'b0;
		end else begin
			if (adv) begin
				result.valid <= v_s1;
			end
			if (fire) begin
				tracking_q  <= tracking_d;
				triggered_q <= triggered_d;
				gesture_q   <= gesture_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && latch_start) begin
			start_x_q    <= px;
			start_y_q    <= py;
			start_time_q <= now_s1;
		end
		if (fire) begin
			result.gesture_state <= gesture_d;
			result.event_kind    <= ev_d;
			result.event_x       <= (ev_d == EV_NONE) ? '0 : px;
			result.event_y       <= (ev_d == EV_NONE) ? '0 : py;
			result.play_click    <= click_d;
		end
	end

	// checks
	`include "long_press_touch_detector_assert.svh"

	`LPTD_ASSERT_IMPL(a_click_on_start, result.valid && result.play_click,
		result.gesture_state == GS_STARTED && result.event_kind == EV_STARTED,
		"click without press start")
	`LPTD_ASSERT_IMPL(a_quiet_position, result.valid && result.event_kind == EV_NONE,
		result.event_x == '0 && result.event_y == '0, "position reported without event")
	`LPTD_ASSERT_IMPL(a_trigger_on_fire, $rose(triggered_q),
		$past(fire) && $past(ph) == PH_STAY, "press fired outside a stay sample")

endmodule

[bench/long_press_touch_detector_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// long_press_touch_detector_checker
// watches the sample, result and apb channels, keeps its own copy of the
// gesture state and configuration, and compares every result transfer with
// the oldest predicted gesture result
// ----------------------------------------------------------------------------
module long_press_touch_detector_checker
	import lptd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	lptd_sample_if            smp,
	lptd_result_if            res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                fail_count,
	output int                pending
);

	localparam int CW = COORD_BITS_DEF;

	typedef struct packed {
		gesture_t      gs;
		event_t        ev;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic          click;
	} gesture_res_t;

	gesture_res_t expected_q[$];

	logic                        cfg_enable;
	logic        [HOLD_BITS-1:0] cfg_hold;
	logic        [MOVE_BITS-1:0] cfg_move;
	logic signed [CW-1:0]        cfg_left;
	logic signed [CW-1:0]        cfg_top;
	logic        [DIM_BITS-1:0]  cfg_width;
	logic        [DIM_BITS-1:0]  cfg_height;

	logic                        holding;
	logic                        fired;
	logic signed [CW-1:0]        anchor_x;
	logic signed [CW-1:0]        anchor_y;
	logic        [31:0]          anchor_ms;
	gesture_t                    gesture_now;

	function automatic string fmt_res(input gesture_res_t r);
		return $sformatf("gs %0d ev %0d x %0d y %0d click %0d",
			r.gs, r.ev, $signed(r.x), $signed(r.y), r.click);
	endfunction

	task automatic predict_gesture(
		input  phase_t               tp,
		input  logic signed [CW-1:0] tx,
		input  logic signed [CW-1:0] ty,
		input  phase_t               mp,
		input  logic signed [CW-1:0] mx,
		input  logic signed [CW-1:0] my,
		input  logic        [31:0]   now,
		output gesture_res_t         r
	);
		phase_t               ph;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		longint               x, y, l, t, w, h, dx, dy, dist2, mm;
		logic        [31:0]   elapsed;
		ph = tp;
		px = tx;
		py = ty;
		// mouse fallback when touch is idle
		if (tp == PH_NONE) begin
			ph = mp;
			px = mx;
			py = my;
		end
		r.ev = EV_NONE;
		r.x = '0;
		r.y = '0;
		r.click = 1'b0;
		if (!cfg_enable || ph == PH_NONE) begin
			holding = 1'b0;
			gesture_now = GS_FAILED;
		end else if (ph == PH_START) begin
			holding = 1'b1;
			fired = 1'b0;
			anchor_x = px;
			anchor_y = py;
			anchor_ms = now;
			gesture_now = GS_UNSURE;
		end else if (ph == PH_STAY) begin
			if (holding && !fired) begin
				x = px;
				y = py;
				l = cfg_left;
				t = cfg_top;
				w = cfg_width;
				h = cfg_height;
				if (x < l || x > l + w || y < t || y > t + h) begin
					holding = 1'b0;
					gesture_now = GS_FAILED;
				end else begin
					dx = x - longint'(anchor_x);
					dy = y - longint'(anchor_y);
					dist2 = dx * dx + dy * dy;
					mm = cfg_move;
					if (dist2 > mm * mm) begin
						holding = 1'b0;
						gesture_now = GS_FAILED;
					end else begin
						elapsed = now - anchor_ms;
						if (elapsed >= cfg_hold) begin
							fired = 1'b1;
							gesture_now = GS_STARTED;
							r.ev = EV_STARTED;
							r.x = px;
							r.y = py;
							r.click = 1'b1;
						end
					end
				end
			end
		end else begin
			if (fired) begin
				gesture_now = GS_ENDED;
				r.ev = EV_ENDED;
				r.x = px;
				r.y = py;
			end else begin
				gesture_now = GS_FAILED;
			end
			holding = 1'b0;
		end
		r.gs = gesture_now;
	endtask

	always @(posedge clk or negedge arst_n) begin
		gesture_res_t want;
		gesture_res_t got;
		if (!arst_n) begin
			cfg_enable = 1'b1;
			cfg_hold = HOLD_RST;
			cfg_move = MOVE_RST;
			cfg_left = '0;
			cfg_top = '0;
			cfg_width = WIDTH_RST;
			cfg_height = HEIGHT_RST;
			holding = 1'b0;
			fired = 1'b0;
			anchor_x = '0;
			anchor_y = '0;
			anchor_ms = '0;
			gesture_now = GS_FAILED;
			expected_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_ENABLE:       cfg_enable = pwdata[0];
					REG_HOLD_MS:      cfg_hold = pwdata[HOLD_BITS-1:0];
					REG_MAX_MOVEMENT: cfg_move = pwdata[MOVE_BITS-1:0];
					REG_VIEW_LEFT:    cfg_left = pwdata[CW-1:0];
					REG_VIEW_TOP:     cfg_top = pwdata[CW-1:0];
					REG_VIEW_WIDTH:   cfg_width = pwdata[DIM_BITS-1:0];
					REG_VIEW_HEIGHT:  cfg_height = pwdata[DIM_BITS-1:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				got.gs = res.gesture_state;
				got.ev = res.event_kind;
				got.x = res.event_x;
				got.y = res.event_y;
				got.click = res.play_click;
				if (expected_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result transfer: expected none, actual %s",
						$time, fmt_res(got));
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t: mismatch: expected %s, actual %s",
							$time, fmt_res(want), fmt_res(got));
					end
				end
			end
			if (smp.valid && smp.ready) begin
				predict_gesture(smp.touch_phase, smp.touch_x, smp.touch_y, smp.mouse_phase,
					smp.mouse_x, smp.mouse_y, smp.now_ms, want);
				expected_q.push_back(want);
			end
			pending <= expected_q.size();
		end
	end

endmodule

[bench/long_press_touch_detector_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// long_press_touch_detector_tb
// drives directed and random touch and mouse gestures through the detector
// under several configurations and idle and stall patterns; the checker predicts and
// compares every result transfer, this module gives the verdict
// ----------------------------------------------------------------------------
module long_press_touch_detector_tb;
	import lptd_pkg::*;

	localparam int CW             = COORD_BITS_DEF;
	localparam int SEGMENTS       = 8;
	localparam int SEGMENT_ITEMS  = 144;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int COORD_MIN      = -4096;
	localparam int COORD_MAX      = 4095;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		phase_t        tp;
		logic [CW-1:0] tx;
		logic [CW-1:0] ty;
		phase_t        mp;
		logic [CW-1:0] mx;
		logic [CW-1:0] my;
		logic [31:0]   now;
	} touch_sample_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int fail_count;
	int pending;
	int idle_pct;
	int stall_pct;
	int idle_cycles;
	int sent_items;
	int set_hold;
	int set_move;
	int set_left;
	int set_top;
	int set_w;
	int set_h;

	lptd_sample_if smp_if ();
	lptd_result_if res_if ();

	long_press_touch_detector i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	long_press_touch_detector_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp        (smp_if),
		.res        (res_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int clip_coord(input int v);
		if (v < COORD_MIN)
			return COORD_MIN;
		if (v > COORD_MAX)
			return COORD_MAX;
		return v;
	endfunction

	task automatic send_sample(input touch_sample_t s);
		while ($urandom_range(99) < idle_pct) begin
			smp_if.valid <= 1'b0;
			@(posedge clk);
		end
		smp_if.valid <= 1'b1;
		smp_if.touch_phase <= s.tp;
		smp_if.touch_x <= s.tx;
		smp_if.touch_y <= s.ty;
		smp_if.mouse_phase <= s.mp;
		smp_if.mouse_x <= s.mx;
		smp_if.mouse_y <= s.my;
		smp_if.now_ms <= s.now;
		do @(posedge clk); while (smp_if.ready !== 1'b1);
		sent_items++;
	endtask

	// mouse carries the gesture only while touch reports no phase
	task automatic emit_sample(input phase_t ph, input int x, input int y,
		input logic [31:0] t, input bit mouse);
		touch_sample_t s;
		s.now = t;
		if (mouse) begin
			s.tp = PH_NONE;
			s.tx = CW'($urandom);
			s.ty = CW'($urandom);
			s.mp = ph;
			s.mx = CW'(x);
			s.my = CW'(y);
		end else begin
			s.tp = ph;
			s.tx = CW'(x);
			s.ty = CW'(y);
			s.mp = phase_t'($urandom_range(3));
			s.mx = CW'($urandom);
			s.my = CW'($urandom);
		end
		send_sample(s);
	endtask

	task automatic send_gesture();
		int          x0, y0, x, y, lim_x, lim_y, j, n, dt;
		logic [31:0] t;
		bit          mouse;
		mouse = ($urandom_range(3) == 0);
		lim_x = (set_left + set_w > COORD_MAX) ? COORD_MAX : set_left + set_w;
		lim_y = (set_top + set_h > COORD_MAX) ? COORD_MAX : set_top + set_h;
		if ($urandom_range(9) == 0) begin
			x0 = int'($urandom_range(8191)) + COORD_MIN;
			y0 = int'($urandom_range(8191)) + COORD_MIN;
		end else begin
			x0 = set_left + int'($urandom_range(lim_x - set_left));
			y0 = set_top + int'($urandom_range(lim_y - set_top));
		end
		j = ($urandom_range(3) == 0) ? set_move * 3 / 2 + 2 : set_move * 3 / 4 + 1;
		if ($urandom_range(3) == 0)
			t = 32'hFFFF_FFFF - $urandom_range(set_hold);
		else
			t = $urandom;
		emit_sample(PH_START, x0, y0, t, mouse);
		x = x0;
		y = y0;
		n = $urandom_range(8, 1);
		repeat (n) begin
			x = clip_coord(x0 + int'($urandom_range(2 * j)) - j);
			y = clip_coord(y0 + int'($urandom_range(2 * j)) - j);
			if ($urandom_range(15) == 0)
				dt = int'($urandom);
			else
				dt = int'($urandom_range(set_hold / 3 + 2));
			t = t + 32'(dt);
			if ($urandom_range(15) == 0)
				emit_sample(PH_NONE, x, y, t, $urandom_range(1));
			else
				emit_sample(PH_STAY, x, y, t, mouse);
		end
		if ($urandom_range(9) != 0)
			emit_sample(PH_END, x, y, t + $urandom_range(50), mouse);
		if ($urandom_range(7) == 0)
			emit_sample(PH_END, x, y, t, mouse);
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input bit en, input int hold, input int mm, input int left,
		input int top, input int w, input int h);
		apb_write(REG_ENABLE, 32'(en));
		apb_write(REG_HOLD_MS, 32'(hold));
		apb_write(REG_MAX_MOVEMENT, 32'(mm));
		apb_write(REG_VIEW_LEFT, 32'(left));
		apb_write(REG_VIEW_TOP, 32'(top));
		apb_write(REG_VIEW_WIDTH, 32'(w));
		apb_write(REG_VIEW_HEIGHT, 32'(h));
		set_hold = hold;
		set_move = mm;
		set_left = left;
		set_top = top;
		set_w = w;
		set_h = h;
	endtask

	task automatic wait_idle();
		smp_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int            seg;
		int            seg_end;
		touch_sample_t noise;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp_if.valid = 1'b0;
		smp_if.touch_phase = PH_NONE;
		smp_if.touch_x = '0;
		smp_if.touch_y = '0;
		smp_if.mouse_phase = PH_NONE;
		smp_if.mouse_x = '0;
		smp_if.mouse_y = '0;
		smp_if.now_ms = '0;
		res_if.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		idle_cycles = 0;
		sent_items = 0;
		set_hold = HOLD_RST;
		set_move = MOVE_RST;
		set_left = 0;
		set_top = 0;
		set_w = WIDTH_RST;
		set_h = HEIGHT_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write to an unmapped register must leave the defaults alone
		apb_write(REG_UNUSED, $urandom);

		emit_sample(PH_NONE, 0, 0, 32'd0, 1'b1);
		emit_sample(PH_STAY, 5, 5, 32'd0, 1'b0);
		emit_sample(PH_END, 5, 5, 32'd0, 1'b0);
		emit_sample(PH_START, 100, 100, 32'd1000, 1'b0);
		emit_sample(PH_STAY, 103, 104, 32'd1200, 1'b0);
		emit_sample(PH_STAY, 106, 108, 32'd1500, 1'b0);
		emit_sample(PH_STAY, 500, 500, 32'd1600, 1'b0);
		emit_sample(PH_END, 107, 109, 32'd1700, 1'b0);
		emit_sample(PH_END, 1, 2, 32'd1800, 1'b0);
		// elapsed time across the wrap of the timestamp
		emit_sample(PH_START, 0, 0, 32'hFFFF_FF00, 1'b1);
		emit_sample(PH_STAY, 0, 0, 32'h0000_00F3, 1'b1);
		emit_sample(PH_STAY, 0, 0, 32'h0000_00F4, 1'b1);
		emit_sample(PH_END, 0, 0, 32'h0000_0100, 1'b1);
		emit_sample(PH_START, 960, 544, 32'd10, 1'b0);
		emit_sample(PH_STAY, 961, 544, 32'd20, 1'b0);
		emit_sample(PH_START, 0, 0, 32'd30, 1'b0);
		emit_sample(PH_STAY, -1, 0, 32'd40, 1'b0);
		emit_sample(PH_START, 0, 0, 32'd0, 1'b0);
		emit_sample(PH_STAY, 7, 8, 32'd0, 1'b0);
		emit_sample(PH_START, COORD_MIN, COORD_MIN, 32'd0, 1'b0);
		emit_sample(PH_STAY, COORD_MIN, COORD_MIN, 32'hFFFF_FFFF, 1'b0);
		emit_sample(PH_START, COORD_MAX, COORD_MAX, 32'd5, 1'b0);
		emit_sample(PH_NONE, COORD_MAX, COORD_MAX, 32'd6, 1'b1);
		emit_sample(PH_STAY, COORD_MAX, COORD_MAX, 32'd7, 1'b0);
		wait_idle();
		apb_write(REG_ENABLE, 32'd0);
		emit_sample(PH_START, 10, 10, 32'd100, 1'b0);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			wait_idle();
			case (seg)
				0: apply_setting(1'b1, 0, 0, COORD_MIN, COORD_MIN, 8191, 8191);
				1: apply_setting(1'b1, 65535, 4095, COORD_MAX, COORD_MAX, 8191, 8191);
				default: apply_setting(seg != 2 && $urandom_range(7) != 0,
					($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1500),
					($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(80),
					($urandom_range(1) == 0) ? int'($urandom_range(8191)) + COORD_MIN
						: int'($urandom_range(200)) - 100,
					($urandom_range(1) == 0) ? int'($urandom_range(8191)) + COORD_MIN
						: int'($urandom_range(200)) - 100,
					$urandom_range(8191), $urandom_range(8191));
			endcase
			case (seg % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 48; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 48; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			seg_end = sent_items + SEGMENT_ITEMS;
			while (sent_items < seg_end) begin
				if ($urandom_range(4) == 0) begin
					noise.tp = phase_t'($urandom_range(3));
					noise.tx = CW'($urandom);
					noise.ty = CW'($urandom);
					noise.mp = phase_t'($urandom_range(3));
					noise.mx = CW'($urandom);
					noise.my = CW'($urandom);
					noise.now = $urandom;
					send_sample(noise);
				end else begin
					send_gesture();
				end
			end
		end

		wait_idle();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
